// ----- rtl/jtag_ir_dr_scan_sequencer_unit_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef JTAG_IR_DR_SCAN_SEQUENCER_UNIT_ASSERT_SVH
`define JTAG_IR_DR_SCAN_SEQUENCER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define JIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define JIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/jids_pkg.sv -----
`default_nettype none

package jids_pkg;

	localparam int IR_LEN_W      = 7;
	localparam int DR_LEN_W      = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_INDEX_W   = 1;
	localparam int LEN_W         = 13;

	localparam logic [LEN_W-1:0] IR_MAX_BITS   = 13'd64;
	localparam logic [LEN_W-1:0] MAX_DATA_BITS = 13'd4096;

	localparam logic [CFG_INDEX_W-1:0] REG_IR_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_DR_LENGTH = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Step positions within the expanded sequence of one item.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_LEAD_FIRST  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SHIFT       = 4'd4;
	localparam logic [STEP_W-1:0] STEP_DR_TAIL_END = 4'd6;
	localparam logic [STEP_W-1:0] STEP_IR_TAIL_END = 4'd8;

	typedef struct packed {
		logic lead_in;
		logic final_bit;
		logic phase;
		logic bit_val;
		logic tdo;
	} scan_desc_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} queue_status_t;

	function automatic logic [STEP_W-1:0] step_start(input scan_desc_t d);
		return d.lead_in ? STEP_LEAD_FIRST : STEP_SHIFT;
	endfunction

	function automatic logic [STEP_W-1:0] step_end(input scan_desc_t d);
		logic [STEP_W-1:0] e;
		if (!d.final_bit) e = STEP_SHIFT;
		else if (d.phase) e = STEP_DR_TAIL_END;
		else e = STEP_IR_TAIL_END;
		return e;
	endfunction

	// TMS level of a step; the shift step carries the final-bit flag.
	function automatic logic step_tms(input logic [STEP_W-1:0] idx, input scan_desc_t d);
		logic t;
		case (idx)
			4'd0, 4'd1: t = 1'b1;
			4'd2, 4'd3: t = 1'b0;
			4'd4:       t = d.final_bit;
			4'd5:       t = 1'b1;
			4'd6:       t = ~d.phase;
			default:    t = 1'b0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/jids_front.sv -----
`default_nettype none

module jids_front import jids_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   scan_bit,
	input  wire logic                   tdo_level,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   q_full,
	output logic                        q_push,
	output scan_desc_t                  q_desc
);

	logic [IR_LEN_W-1:0] ir_length_q;
	logic [DR_LEN_W-1:0] dr_length_q;
	logic                scan_phase_q;
	logic [LEN_W-1:0]    bit_count_q;
	logic [LEN_W-1:0]    ir_eff;
	logic [LEN_W-1:0]    dr_eff;
	logic [LEN_W-1:0]    len;
	logic [LEN_W:0]      next_count;
	logic                final_bit;

	always_comb begin
		if (ir_length_q == '0) ir_eff = 13'd1;
		else if ({6'd0, ir_length_q} > IR_MAX_BITS) ir_eff = IR_MAX_BITS;
		else ir_eff = {6'd0, ir_length_q};

		if (dr_length_q == '0) dr_eff = 13'd1;
		else if (dr_length_q > MAX_DATA_BITS) dr_eff = MAX_DATA_BITS;
		else dr_eff = dr_length_q;

		len        = scan_phase_q ? dr_eff : ir_eff;
		next_count = {1'b0, bit_count_q} + 14'd1;
		// A length lowered below the running count also ends the register.
		final_bit  = next_count >= {1'b0, len};

		q_desc.lead_in   = !scan_phase_q && (bit_count_q == '0);
		q_desc.final_bit = final_bit;
		q_desc.phase     = scan_phase_q;
		q_desc.bit_val   = scan_bit;
		q_desc.tdo       = tdo_level;
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_length_q  <= 7'd1;
			dr_length_q  <= 13'd1;
			scan_phase_q <= 1'b0;
			bit_count_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IR_LENGTH: ir_length_q <= cfg_data[IR_LEN_W-1:0];
					REG_DR_LENGTH: dr_length_q <= cfg_data[DR_LEN_W-1:0];
					default: ;
				endcase
			end
			if (q_push) begin
				if (final_bit) begin
					scan_phase_q <= ~scan_phase_q;
					bit_count_q  <= '0;
				end else begin
					bit_count_q  <= next_count[LEN_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/jids_queue.sv -----
`default_nettype none

module jids_queue import jids_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire scan_desc_t push_desc,
	input  wire logic    pop,
	output scan_desc_t   head_desc,
	output queue_status_t status
);

	scan_desc_t        entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign status.full  = count_q == QCNT_W'(QDEPTH);
	assign status.empty = count_q == '0;
	assign status.count = count_q;
	assign head_desc    = entry_q[rd_ptr_q];
	assign do_pop       = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/jids_back.sv -----
`default_nettype none

module jids_back import jids_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire scan_desc_t head_desc,
	input  wire logic q_empty,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic      tms,
	output logic      tdi,
	output logic      is_shift,
	output logic      captured_bit,
	output logic      in_data_scan,
	output logic      last
);

	scan_desc_t        cur_q;
	logic              busy_q;
	logic [STEP_W-1:0] idx_q;
	logic              out_valid_q;
	logic              tms_q, tdi_q, shift_q, cap_q, phase_q, last_q;
	logic              advance;
	logic              at_end;
	logic              shift_step;

	assign advance    = !out_valid_q || !out_stall;
	assign at_end     = idx_q == step_end(cur_q);
	assign shift_step = idx_q == STEP_SHIFT;
	// The next request is taken as the current one emits its final step.
	assign q_pop      = advance && !q_empty && (!busy_q || at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
			if (busy_q && !at_end) begin
				idx_q <= idx_q + STEP_W'(1);
			end else if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= step_start(head_desc);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= head_desc;
		if (advance && busy_q) begin
			tms_q   <= step_tms(idx_q, cur_q);
			tdi_q   <= shift_step ? cur_q.bit_val : 1'b1;
			shift_q <= shift_step;
			cap_q   <= shift_step ? cur_q.tdo : 1'b0;
			phase_q <= cur_q.phase;
			last_q  <= at_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign tms          = tms_q;
	assign tdi          = tdi_q;
	assign is_shift     = shift_q;
	assign captured_bit = cap_q;
	assign in_data_scan = phase_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- rtl/jtag_ir_dr_scan_sequencer_unit.sv -----
// JTAG instruction-then-data scan sequencer.
// Input channel (in_valid/in_stall): one request per scan bit, carrying
// scan_bit and the tdo_level seen on its shift step; the ir_length
// instruction bits come first, then the dr_length data bits.
// Output channel (out_valid/out_stall): one request per TCK step with tms,
// tdi, is_shift, captured_bit, in_data_scan and last; last marks the final
// step produced by an input bit.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 ir_length,
// 1 dr_length) in the same cycle; write only while the block is idle.
// Throughput is one TCK step per cycle while out_stall is low. A plain
// shift bit yields its shift step alone; the step expander adds lead-in
// steps to the first instruction bit, tail steps to the last instruction
// and data bits. When idle, a bit passes the queue and cur_q registers.
// A four-entry queue separates bit classification from step expansion, so
// inputs keep being taken while out_stall holds the output register; once
// the queue fills, in_stall rises. Reset empties the queue, drops any
// pending step and restores both lengths to 1 at the start of an
// instruction scan.
`default_nettype none

module jtag_ir_dr_scan_sequencer_unit import jids_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   scan_bit,
	input  wire logic                   tdo_level,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        tms,
	output logic                        tdi,
	output logic                        is_shift,
	output logic                        captured_bit,
	output logic                        in_data_scan,
	output logic                        last,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

`include "jtag_ir_dr_scan_sequencer_unit_assert.svh"

	scan_desc_t    push_desc;
	scan_desc_t    head_desc;
	queue_status_t q_status;
	logic          q_push;
	logic          q_pop;

	jids_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.scan_bit  (scan_bit),
		.tdo_level (tdo_level),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_status.full),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	jids_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.head_desc (head_desc),
		.status    (q_status)
	);

	jids_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_desc    (head_desc),
		.q_empty      (q_status.empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tms          (tms),
		.tdi          (tdi),
		.is_shift     (is_shift),
		.captured_bit (captured_bit),
		.in_data_scan (in_data_scan),
		.last         (last)
	);

	`JIDS_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, q_status.count <= QCNT_W'(QDEPTH), "queue count above depth")
	`JIDS_ASSERT_IMPL(a_nav_levels, clk, arst_n, out_valid && !is_shift, tdi && !captured_bit, "navigation step with bad TDI or capture")
	`JIDS_ASSERT_IMPL(a_dr_plain_last, clk, arst_n, out_valid && is_shift && !tms && in_data_scan, last, "plain data shift not marked last")
	`JIDS_ASSERT_NEXT(a_full_push, clk, arst_n, q_status.full && !q_pop, q_status.full, "queue left full state without pop")

endmodule

`default_nettype wire
